// File: design/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Shared types, codes and helper functions for the primitive assembler.
// ----------------------------------------------------------------------------
package pa_pkg;

    // Primitive kinds as carried on the input stream.
    localparam logic [2:0] KIND_QUADS = 3'd0;
    localparam logic [2:0] KIND_TRIS  = 3'd1;
    localparam logic [2:0] KIND_STRIP = 3'd2;
    localparam logic [2:0] KIND_FAN   = 3'd3;

    // Internal command codes of the kinds.
    localparam logic [7:0] CODE_QUADS = 8'h80;
    localparam logic [7:0] CODE_TRIS  = 8'h90;
    localparam logic [7:0] CODE_STRIP = 8'h98;
    localparam logic [7:0] CODE_FAN   = 8'hA0;
    localparam logic [7:0] CODE_NONE  = 8'h00;

    // Emission queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Number of vertex slots carried by one queue entry.
    localparam int SLOT_COUNT  = 4;

    // Emission patterns handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,   // slot 0
        OP_TRIPLE = 2'd1,   // slots 0, 1, 2
        OP_QUAD   = 2'd2    // slots 0, 1, 2, 2, 3, 0
    } op_t;

    function automatic logic [7:0] kind_code(input logic [2:0] kind);
        logic [7:0] code;
        case (kind)
            KIND_QUADS: code = CODE_QUADS;
            KIND_TRIS:  code = CODE_TRIS;
            KIND_STRIP: code = CODE_STRIP;
            KIND_FAN:   code = CODE_FAN;
            default:    code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Index of the final word of a run, for each pattern.
    function automatic logic [2:0] op_last_idx(input op_t op);
        logic [2:0] idx;
        case (op)
            OP_SINGLE: idx = 3'd0;
            OP_TRIPLE: idx = 3'd2;
            OP_QUAD:   idx = 3'd5;
            default:   idx = 3'd0;
        endcase
        return idx;
    endfunction

    // Which slot feeds a given word of a run.
    function automatic logic [1:0] op_slot(input op_t op, input logic [2:0] idx);
        logic [1:0] slot;
        slot = 2'd0;
        case (op)
            OP_TRIPLE: begin
                slot = idx[1:0];
            end
            OP_QUAD: begin
                case (idx)
                    3'd0:    slot = 2'd0;
                    3'd1:    slot = 2'd1;
                    3'd2:    slot = 2'd2;
                    3'd3:    slot = 2'd2;
                    3'd4:    slot = 2'd3;
                    default: slot = 2'd0;
                endcase
            end
            default: begin
                slot = 2'd0;
            end
        endcase
        return slot;
    endfunction

endpackage

// File: design/primitive_assembler_top.sv
// ----------------------------------------------------------------------------
// primitive_assembler_top
// Turns a stream of tagged vertices (quads, triangles, strips, fans) into a
// plain triangle list.
// ----------------------------------------------------------------------------
// One vertex is accepted per word on the slave side, tagged in tuser with its
// primitive kind and a start-of-primitive mark; the master side delivers the
// resulting triangle-list vertices, with tlast set on the final word produced
// for each input vertex. The front end takes a new vertex in every cycle that
// its four-entry command queue has room, so kinds that produce one word or
// none run at one vertex per cycle while the output flows. The back end sends
// one word per cycle through its output register while m_tready is high,
// which sets the sustained rate for the heavier kinds: a strip or fan vertex
// yields three words, a complete quad six over its four vertices, and a
// triangle vertex one. The output register reloads as its word is taken, and
// the queue lets the input keep flowing while a long run drains. Vertices of
// an unfinished quad, and those of an unknown kind, produce nothing but still
// enter the history. After reset the first vertex always starts a primitive.
// ----------------------------------------------------------------------------
module primitive_assembler_top #(
    parameter int VERTEX_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave side: one vertex per word.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] vertex_word
    input  logic [3:0]  s_tuser,    // [2:0] prim_kind, [3] first_vertex
    // Master side: triangle-list vertices.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] out_vertex
    output logic        m_tlast     // last_of_run
);
    import pa_pkg::*;

    logic                                     accept;
    logic                                     push_valid;
    op_t                                      push_op;
    logic [SLOT_COUNT-1:0][VERTEX_WIDTH-1:0]  push_slots;
    logic                                     queue_full;
    logic                                     cmd_valid;
    logic                                     cmd_ready;
    op_t                                      cmd_op;
    logic [SLOT_COUNT-1:0][VERTEX_WIDTH-1:0]  cmd_slots;

    // Every vertex waits for queue room, so a command is never lost.
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    pa_front #(
        .VERTEX_WIDTH (VERTEX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .prim_kind    (s_tuser[2:0]),
        .first_vertex (s_tuser[3]),
        .vertex_word  (s_tdata),
        .push_valid   (push_valid),
        .push_op      (push_op),
        .push_slots   (push_slots)
    );

    pa_queue #(
        .VERTEX_WIDTH (VERTEX_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_slots (push_slots),
        .full       (queue_full),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_op     (cmd_op),
        .pop_slots  (cmd_slots)
    );

    pa_back #(
        .VERTEX_WIDTH (VERTEX_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_slots (cmd_slots),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: design/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front
// Accepts vertices, tracks the primitive history and classifies each vertex
// into an emission command for the queue.
// ----------------------------------------------------------------------------
module pa_front #(
    parameter int VERTEX_WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       accept,
    input  logic [2:0]                                 prim_kind,
    input  logic                                       first_vertex,
    input  logic [31:0]                                vertex_word,
    output logic                                       push_valid,
    output pa_pkg::op_t                                push_op,
    output logic [pa_pkg::SLOT_COUNT-1:0][VERTEX_WIDTH-1:0] push_slots
);
    import pa_pkg::*;

    localparam int CW = (VERTEX_WIDTH < 32) ? VERTEX_WIDTH : 32;

    logic [2:0][VERTEX_WIDTH-1:0] history_reg, history_next;
    logic [VERTEX_WIDTH-1:0]      anchor_reg, anchor_next;
    logic [1:0]                   pos_reg, pos_next;
    logic                         two_seen_reg, two_seen_next;

    logic [VERTEX_WIDTH-1:0] cur;
    logic [1:0]              pos;
    logic                    two_seen;
    logic                    emit;

    always_comb begin
        cur      = VERTEX_WIDTH'(vertex_word[CW-1:0]);
        pos      = first_vertex ? 2'd0 : pos_reg;
        two_seen = first_vertex ? 1'b0 : two_seen_reg;

        anchor_next = anchor_reg;
        if (pos == 2'd0 && !two_seen) begin
            anchor_next = cur;
        end

        emit       = 1'b0;
        push_op    = OP_SINGLE;
        push_slots = '0;
        case (kind_code(prim_kind))
            CODE_QUADS: begin
                emit          = (pos == 2'd3);
                push_op       = OP_QUAD;
                push_slots[0] = history_reg[2];
                push_slots[1] = history_reg[1];
                push_slots[2] = history_reg[0];
                push_slots[3] = cur;
            end
            CODE_TRIS: begin
                emit          = 1'b1;
                push_slots[0] = cur;
            end
            CODE_STRIP: begin
                emit    = two_seen;
                push_op = OP_TRIPLE;
                // Odd positions swap the winding.
                push_slots[0] = pos[0] ? history_reg[0] : history_reg[1];
                push_slots[1] = pos[0] ? history_reg[1] : history_reg[0];
                push_slots[2] = cur;
            end
            CODE_FAN: begin
                emit          = two_seen;
                push_op       = OP_TRIPLE;
                push_slots[0] = anchor_next;
                push_slots[1] = history_reg[0];
                push_slots[2] = cur;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        push_valid = accept && emit;

        history_next  = {history_reg[1], history_reg[0], cur};
        two_seen_next = two_seen || (pos != 2'd0);
        pos_next      = pos + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg  <= '0;
            anchor_reg   <= '0;
            pos_reg      <= 2'd0;
            two_seen_reg <= 1'b0;
        end else if (accept) begin
            history_reg  <= history_next;
            anchor_reg   <= anchor_next;
            pos_reg      <= pos_next;
            two_seen_reg <= two_seen_next;
        end
    end

endmodule

// File: design/pa_queue.sv
// ----------------------------------------------------------------------------
// pa_queue
// Short first-in first-out queue of emission commands between the front end
// and the back end.
// ----------------------------------------------------------------------------
module pa_queue #(
    parameter int VERTEX_WIDTH = 32
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            push_valid,
    input  pa_pkg::op_t                                     push_op,
    input  logic [pa_pkg::SLOT_COUNT-1:0][VERTEX_WIDTH-1:0] push_slots,
    output logic                                            full,
    output logic                                            pop_valid,
    input  logic                                            pop_ready,
    output pa_pkg::op_t                                     pop_op,
    output logic [pa_pkg::SLOT_COUNT-1:0][VERTEX_WIDTH-1:0] pop_slots
);
    import pa_pkg::*;

    op_t                                   op_mem  [QUEUE_DEPTH];
    logic [SLOT_COUNT-1:0][VERTEX_WIDTH-1:0] slot_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb begin
        full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        pop_valid = (count_reg != '0);
        pop_op    = op_mem[rd_ptr_reg];
        pop_slots = slot_mem[rd_ptr_reg];

        do_push = push_valid && !full;
        do_pop  = pop_valid && pop_ready;

        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            op_mem[wr_ptr_reg]   <= push_op;
            slot_mem[wr_ptr_reg] <= push_slots;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/pa_back.sv
// ----------------------------------------------------------------------------
// pa_back
// Walks the command at the head of the queue and presents one vertex word a
// cycle through an output register while m_tready is high.
// ----------------------------------------------------------------------------
module pa_back #(
    parameter int VERTEX_WIDTH = 32
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            cmd_valid,
    output logic                                            cmd_ready,
    input  pa_pkg::op_t                                     cmd_op,
    input  logic [pa_pkg::SLOT_COUNT-1:0][VERTEX_WIDTH-1:0] cmd_slots,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    output logic [31:0]                                     m_tdata,
    output logic                                            m_tlast
);
    import pa_pkg::*;

    localparam int OW = (VERTEX_WIDTH < 32) ? VERTEX_WIDTH : 32;

    logic [2:0]              idx_reg, idx_next;
    logic                    valid_reg, valid_next;
    logic [31:0]             data_reg, data_next;
    logic                    last_reg, last_next;
    logic                    load, is_last;
    logic [VERTEX_WIDTH-1:0] picked;

    always_comb begin
        load      = cmd_valid && (!valid_reg || m_tready);
        is_last   = (idx_reg == op_last_idx(cmd_op));
        cmd_ready = load && is_last;
        picked    = cmd_slots[op_slot(cmd_op, idx_reg)];

        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load) begin
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            valid_next = 1'b1;
            data_next  = 32'(picked[OW-1:0]);
            last_next  = is_last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// File: verif/primitive_assembler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_assembler_top_tb
// Self-checking bench for the primitive assembler. A driver feeds tagged
// vertices from a backlog and a monitor checks every triangle-list word. The
// expected words come from a behavioural copy of the assembler's history.
// ----------------------------------------------------------------------------
// A directed opening covers the start-up case, every primitive kind, the
// ignored kinds, a kind change inside a primitive and an unfinished quad.
// After it comes a burst that stalls the receiver for a long stretch while
// the sender keeps pushing fans. The rest is mostly well-formed primitives
// with random payloads, plus some noise with random kinds and start marks.
// Both sides idle at random. The bench reports mismatches, stray words and
// a timeout.
// ----------------------------------------------------------------------------
module primitive_assembler_top_tb;

    import pa_pkg::*;

    // Kinds that the assembler ignores.
    localparam logic [2:0] KIND_OTHER_FIRST = 3'd4;
    localparam logic [2:0] KIND_OTHER_LAST  = 3'd7;

    localparam int TARGET_ITEMS     = 500;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 32;
    localparam int CYCLE_LIMIT      = 800_000;
    localparam int MAX_REPORTED     = 10;

    // One pending input word, with the idle time the sender leaves before it.
    typedef struct {
        logic [2:0]  kind;
        logic        start;
        logic [31:0] word;
        int          gap;
        bit          drain_first;   // wait until every expected word has come
        bit          hold_sink;     // start the long receiver hold on acceptance
    } vertex_item_t;

    // One expected word of the triangle list.
    typedef struct packed {
        logic [31:0] vertex;
        logic        last;
    } list_word_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] vertex_word
    logic [3:0]  s_tuser  = '0;     // [2:0] prim_kind, [3] first_vertex
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] out_vertex
    logic        m_tlast;           // last_of_run

    vertex_item_t vertex_backlog [$];
    list_word_t   list_due [$];
    vertex_item_t cur_item;
    list_word_t   due_word;

    // Behavioural copy of the assembler state.
    logic [31:0] vtx_hist [3];
    logic [31:0] anchor_vtx;
    logic [1:0]  slot_pos;
    logic        pair_seen;

    int   gap_left;
    logic hold_req = 1'b0;
    int   sink_left;
    logic sink_open;
    int   cycle_count = 0;
    int   error_count = 0;
    int   words_checked = 0;
    int   kind_hits [8];

    primitive_assembler_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Works out the triangle-list words caused by one accepted vertex and
    // advances the history, exactly as the assembler does.
    task automatic assemble_vertex(input logic [2:0] kind, input logic start,
                                   input logic [31:0] word);
        logic [31:0] run [6];
        int n;
        n = 0;
        if (start) begin
            slot_pos  = '0;
            pair_seen = 1'b0;
        end
        // The first vertex of a primitive becomes the fan anchor.
        if (slot_pos == 2'd0 && !pair_seen) begin
            anchor_vtx = word;
        end
        case (kind)
            KIND_QUADS: begin
                if (slot_pos == 2'd3) begin
                    run[0] = vtx_hist[2];
                    run[1] = vtx_hist[1];
                    run[2] = vtx_hist[0];
                    run[3] = vtx_hist[0];
                    run[4] = word;
                    run[5] = vtx_hist[2];
                    n = 6;
                end
            end
            KIND_TRIS: begin
                run[0] = word;
                n = 1;
            end
            KIND_STRIP: begin
                if (pair_seen) begin
                    // Odd positions swap the winding.
                    run[0] = slot_pos[0] ? vtx_hist[0] : vtx_hist[1];
                    run[1] = slot_pos[0] ? vtx_hist[1] : vtx_hist[0];
                    run[2] = word;
                    n = 3;
                end
            end
            KIND_FAN: begin
                if (pair_seen) begin
                    run[0] = anchor_vtx;
                    run[1] = vtx_hist[0];
                    run[2] = word;
                    n = 3;
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < n; i++) begin
            list_due.insert(list_due.size(), '{vertex: run[i], last: (i == n - 1)});
        end
        vtx_hist[2] = vtx_hist[1];
        vtx_hist[1] = vtx_hist[0];
        vtx_hist[0] = word;
        if (slot_pos != 2'd0) begin
            pair_seen = 1'b1;
        end
        slot_pos = slot_pos + 2'd1;
    endtask

    task automatic queue_vertex(input logic [2:0] kind, input logic start,
                                input logic [31:0] word, input int gap,
                                input bit drain_first, input bit hold_sink);
        vertex_backlog.insert(vertex_backlog.size(),
                              '{kind: kind, start: start, word: word, gap: gap,
                                drain_first: drain_first, hold_sink: hold_sink});
    endtask

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic flag_error(input string why);
        error_count++;
        if (error_count <= MAX_REPORTED) begin
            $display("ERROR at cycle %0d: %s", cycle_count, why);
        end
    endtask

    // Sender: presents backlog words one at a time and predicts each one that
    // is taken. The long receiver hold is requested through hold_req.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            hold_req <= 1'b0;
            gap_left = 0;
            vtx_hist[0] = '0;
            vtx_hist[1] = '0;
            vtx_hist[2] = '0;
            anchor_vtx = '0;
            slot_pos = '0;
            pair_seen = 1'b0;
        end else begin
            hold_req <= s_tvalid && s_tready && cur_item.hold_sink;
            if (s_tvalid && s_tready) begin
                assemble_vertex(cur_item.kind, cur_item.start, cur_item.word);
                kind_hits[cur_item.kind]++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (vertex_backlog.size() != 0 &&
                             !(vertex_backlog[0].drain_first && list_due.size() != 0)) begin
                    cur_item = vertex_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.word;
                    s_tuser  <= {cur_item.start, cur_item.kind};
                    if (vertex_backlog.size() != 0) begin
                        gap_left = vertex_backlog[0].gap;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every word taken and runs its own ready pattern, with
    // one long hold when the sender asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_left = 0;
            sink_open = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (list_due.size() == 0) begin
                    flag_error($sformatf("unexpected word %h, last %b", m_tdata, m_tlast));
                end else begin
                    due_word = list_due.pop_front();
                    words_checked++;
                    if (m_tdata !== due_word.vertex) begin
                        flag_error($sformatf("vertex: expected %h, got %h",
                                             due_word.vertex, m_tdata));
                    end
                    if (m_tlast !== due_word.last) begin
                        flag_error($sformatf("last of run on vertex %h: expected %b, got %b",
                                             due_word.vertex, due_word.last, m_tlast));
                    end
                end
            end
            if (hold_req) begin
                sink_left = SINK_HOLD_CYCLES;
                sink_open = 1'b0;
            end else if (sink_left > 0) begin
                sink_left--;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        sink_open = 1'b1;
                        sink_left = $urandom_range(1, 30);
                    end
                    6, 7, 8: begin
                        sink_open = 1'b0;
                        sink_left = $urandom_range(1, 3);
                    end
                    default: begin
                        sink_open = 1'b0;
                        sink_left = $urandom_range(8, 40);
                    end
                endcase
            end
            m_tready <= sink_open;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words still due",
                     cycle_count, list_due.size());
            $display("primitive_assembler_top regression: fail");
            $finish;
        end
    end

    initial begin
        logic [2:0] kind;
        int len;
        bit calm;
        bit drain;

        // Start-up: no start mark, and a fan straight after reset. The third
        // and fourth vertices emit with the first one as the anchor.
        queue_vertex(KIND_FAN, 1'b0, 32'h0000_0000, 0, 1'b0, 1'b0);
        queue_vertex(KIND_FAN, 1'b0, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        queue_vertex(KIND_FAN, 1'b0, 32'hA5A5_A5A5, 1, 1'b0, 1'b0);
        queue_vertex(KIND_FAN, 1'b0, 32'h5A5A_5A5A, 0, 1'b0, 1'b0);
        // A complete quad.
        queue_vertex(KIND_QUADS, 1'b1, 32'h0000_0001, 0, 1'b0, 1'b0);
        queue_vertex(KIND_QUADS, 1'b0, 32'h0000_0002, 2, 1'b0, 1'b0);
        queue_vertex(KIND_QUADS, 1'b0, 32'h8000_0000, 0, 1'b0, 1'b0);
        queue_vertex(KIND_QUADS, 1'b0, 32'h7FFF_FFFF, 0, 1'b0, 1'b0);
        // A strip of five, so both windings appear.
        for (int i = 0; i < 5; i++) begin
            queue_vertex(KIND_STRIP, i == 0, 32'h1111_1111 * (i + 1), 0, 1'b0, 1'b0);
        end
        queue_vertex(KIND_TRIS, 1'b1, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        queue_vertex(KIND_TRIS, 1'b0, 32'h0000_0000, 0, 1'b0, 1'b0);
        // Ignored kinds still feed the history; a fan then picks it up
        // without a new start mark.
        for (int k = KIND_OTHER_FIRST; k <= KIND_OTHER_LAST; k++) begin
            queue_vertex(k[2:0], k == KIND_OTHER_FIRST, 32'hC0DE_0000 + k, 0, 1'b0, 1'b0);
        end
        queue_vertex(KIND_FAN, 1'b0, 32'hFACE_0001, 0, 1'b0, 1'b0);
        // An unfinished quad cut short by a new triangle.
        queue_vertex(KIND_QUADS, 1'b1, 32'hDEAD_0001, 0, 1'b0, 1'b0);
        queue_vertex(KIND_QUADS, 1'b0, 32'hDEAD_0002, 0, 1'b0, 1'b0);
        queue_vertex(KIND_QUADS, 1'b0, 32'hDEAD_0003, 0, 1'b0, 1'b0);
        queue_vertex(KIND_TRIS, 1'b1, 32'hBEEF_0001, 0, 1'b0, 1'b0);

        // Back-pressure burst: wait for an empty pipeline, stall the receiver
        // for a long stretch and keep offering fans until the input stalls.
        queue_vertex(KIND_FAN, 1'b1, $urandom(), 0, 1'b1, 1'b1);
        for (int i = 0; i < 39; i++) begin
            queue_vertex(KIND_FAN, 1'b0, $urandom(), 0, 1'b0, 1'b0);
        end

        // Random part: mostly well-formed primitives, some noise.
        while (vertex_backlog.size() < TARGET_ITEMS) begin
            calm  = ($urandom_range(0, 3) == 0);
            drain = ($urandom_range(0, 49) == 0);
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        kind = KIND_QUADS;
                        len  = 4 * $urandom_range(1, 3);
                        if ($urandom_range(0, 5) == 0) begin
                            len += $urandom_range(1, 3);
                        end
                    end
                    3, 4: begin
                        kind = KIND_TRIS;
                        len  = 3 * $urandom_range(1, 4);
                    end
                    5, 6, 7, 8: begin
                        kind = ($urandom_range(0, 1) == 0) ? KIND_STRIP : KIND_FAN;
                        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                           : $urandom_range(3, 12);
                    end
                    default: begin
                        kind = 3'($urandom_range(KIND_OTHER_FIRST, KIND_OTHER_LAST));
                        len  = $urandom_range(1, 4);
                    end
                endcase
                for (int i = 0; i < len; i++) begin
                    queue_vertex(kind, i == 0, $urandom(), calm ? 0 : pick_gap(),
                                 drain && i == 0, 1'b0);
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    queue_vertex(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                 $urandom(), calm ? 0 : pick_gap(), 1'b0, 1'b0);
                end
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (vertex_backlog.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (list_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d vertices: quads %0d, triangles %0d, strips %0d, fans %0d, other %0d",
                 kind_hits[KIND_QUADS] + kind_hits[KIND_TRIS] + kind_hits[KIND_STRIP] +
                 kind_hits[KIND_FAN] + kind_hits[4] + kind_hits[5] + kind_hits[6] +
                 kind_hits[7],
                 kind_hits[KIND_QUADS], kind_hits[KIND_TRIS], kind_hits[KIND_STRIP],
                 kind_hits[KIND_FAN],
                 kind_hits[4] + kind_hits[5] + kind_hits[6] + kind_hits[7]);
        $display("Checked %0d triangle-list words in %0d cycles, %0d errors",
                 words_checked, cycle_count, error_count);
        if (error_count == 0 && list_due.size() == 0) begin
            $display("primitive_assembler_top regression: pass");
        end else begin
            $display("primitive_assembler_top regression: fail");
        end
        $finish;
    end

endmodule
